[src/hwf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hwf_pkg;

   localparam int DATA_W = 32;
   // Multiplier operands carry one extra bit so unsigned gains and negated values fit.
   localparam int OPND_W = DATA_W + 1;
   localparam int ADDR_W = 5;
   localparam int STEP_W = 4;

   typedef enum logic [1:0] {
      WALL_OUTSIDE = 2'd0,
      WALL_INSIDE  = 2'd1,
      WALL_PUNCHED = 2'd2
   } wall_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DONE
   } ctl_state_type;

   localparam logic [2:0] REG_STIFFNESS  = 3'd0;
   localparam logic [2:0] REG_DAMP_IN    = 3'd1;
   localparam logic [2:0] REG_DAMP_OUT   = 3'd2;
   localparam logic [2:0] REG_THICKNESS  = 3'd3;
   localparam logic [2:0] REG_DAMP_OFFS  = 3'd4;

   localparam logic [STEP_W-1:0] STEP_NV0    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_NV1    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_NV2    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SPRING = 4'd3;
   localparam logic [STEP_W-1:0] STEP_VSAT   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DAMP   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SUM    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_SCALAR = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FX     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_FY     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_FZ     = 4'd10;
   localparam logic [STEP_W-1:0] STEP_LAST   = 4'd11;

endpackage

`default_nettype wire

[src/hwf_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module hwf_mul import hwf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic signed [OPND_W-1:0]                op_a,
   input  wire logic signed [OPND_W-1:0]                op_b,
   output logic signed [2*OPND_W-FRAC_BITS-1:0]         trunc_q
);

   logic signed [2*OPND_W-1:0] prod_ff;
   logic signed [2*OPND_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Dropping the low fraction bits of a two's complement value rounds toward minus infinity.
   assign trunc_q = prod_ff[2*OPND_W-1:FRAC_BITS];

endmodule

`default_nettype wire

[src/hysteretic_wall_force_core.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    depth, normal, velocity, force_in
// rsp       out        rsp_valid/rsp_ready    force_out, wall_mode
// csr       in         APB-style, pready = 1  five gain and geometry registers
//
// One item keeps the block busy after its transfer; eight products
// go through a single 33x33 multiplier with a register at its output.
// The result is loaded into the output register before the block returns to idle,
// so the next item is taken only once the last result has reached the output register.
// A finished result waits, and holds off the input, only while the output is still full.
// Reset zeroes the configuration registers and output valid and sets the wall mode to inside.
`timescale 1ns / 1ps
`default_nettype none

module hysteretic_wall_force_core import hwf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [DATA_W-1:0]  req_depth,
   input  wire logic signed [DATA_W-1:0]  req_normal_x,
   input  wire logic signed [DATA_W-1:0]  req_normal_y,
   input  wire logic signed [DATA_W-1:0]  req_normal_z,
   input  wire logic signed [DATA_W-1:0]  req_velocity_x,
   input  wire logic signed [DATA_W-1:0]  req_velocity_y,
   input  wire logic signed [DATA_W-1:0]  req_velocity_z,
   input  wire logic signed [DATA_W-1:0]  req_force_in_x,
   input  wire logic signed [DATA_W-1:0]  req_force_in_y,
   input  wire logic signed [DATA_W-1:0]  req_force_in_z,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [DATA_W-1:0]       rsp_force_out_x,
   output logic signed [DATA_W-1:0]       rsp_force_out_y,
   output logic signed [DATA_W-1:0]       rsp_force_out_z,
   output logic [1:0]                     rsp_wall_mode,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [ADDR_W-1:0]         csr_paddr,
   input  wire logic [DATA_W-1:0]         csr_pwdata,
   output logic [DATA_W-1:0]              csr_prdata,
   output logic                           csr_pready
);

   localparam int TRUNC_W = 2*OPND_W - FRAC_BITS;
   localparam int ACC_W   = TRUNC_W + 2;

   // Configuration registers.
   logic [DATA_W-1:0]         stiffness_ff;
   logic [DATA_W-1:0]         damp_in_ff;
   logic [DATA_W-1:0]         damp_out_ff;
   logic [DATA_W-2:0]         thickness_ff;
   logic signed [DATA_W-1:0]  damp_offs_ff;

   // Control.
   ctl_state_type             state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   wall_mode_type             mode_ff, mode_in;
   logic                      stiff_en_ff, stiff_en_in;
   logic                      damp_en_ff, damp_en_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_load;
   logic                      req_xfer;
   logic                      csr_wr;

   // Captured item and working values.
   logic signed [DATA_W-1:0]  depth_ff;
   logic signed [DATA_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic signed [DATA_W-1:0]  vx_ff, vy_ff, vz_ff;
   logic signed [DATA_W-1:0]  fx_in_ff, fy_in_ff, fz_in_ff;
   logic signed [DATA_W-1:0]  vn_ff;
   logic signed [DATA_W-1:0]  scalar_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DATA_W-1:0]  fx_out_ff, fy_out_ff, fz_out_ff;

   // Output register, so a waiting result does not hold the next item off.
   logic signed [DATA_W-1:0]  out_fx_ff, out_fy_ff, out_fz_ff;
   wall_mode_type             out_mode_ff;

   logic signed [OPND_W-1:0]  mul_a, mul_b;
   logic signed [TRUNC_W-1:0] prod_q;
   logic signed [ACC_W-1:0]   prod_ext;

   logic signed [DATA_W:0]    depth_wide;
   logic signed [DATA_W:0]    thk_neg;

   function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-DATA_W:0] upper;
      begin
         upper = x[ACC_W-1:DATA_W-1];
         if ((&upper) || (~|upper)) begin
            sat_acc = x[DATA_W-1:0];
         end else if (x[ACC_W-1]) begin
            sat_acc = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            sat_acc = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   endfunction

   assign req_xfer   = req_valid && req_ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[ADDR_W-1:2])
         REG_STIFFNESS: csr_prdata = stiffness_ff;
         REG_DAMP_IN:   csr_prdata = damp_in_ff;
         REG_DAMP_OUT:  csr_prdata = damp_out_ff;
         REG_THICKNESS: csr_prdata = {1'b0, thickness_ff};
         REG_DAMP_OFFS: csr_prdata = damp_offs_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // Wall mode update from the incoming depth, evaluated at the input transfer.
   assign depth_wide = {req_depth[DATA_W-1], req_depth};
   assign thk_neg    = -$signed({2'b00, thickness_ff});

   always_comb begin
      mode_in     = mode_ff;
      stiff_en_in = 1'b0;
      if (mode_in == WALL_OUTSIDE && req_depth[DATA_W-1]) begin
         mode_in = WALL_INSIDE;
      end
      if (mode_in == WALL_INSIDE) begin
         if (depth_wide < thk_neg) begin
            mode_in = WALL_PUNCHED;
         end else if (!req_depth[DATA_W-1] && (|req_depth)) begin
            mode_in = WALL_OUTSIDE;
         end else begin
            stiff_en_in = 1'b1;
         end
      end
      if (mode_in == WALL_PUNCHED && !req_depth[DATA_W-1] && (|req_depth)) begin
         mode_in = WALL_OUTSIDE;
      end
      damp_en_in = (req_depth < damp_offs_ff) && (mode_in != WALL_PUNCHED);
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_BUSY;
               step_in  = STEP_NV0;
            end
         end
         ST_BUSY: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_NV0;
         mode_ff      <= WALL_INSIDE;
         stiff_en_ff  <= 1'b0;
         damp_en_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         stiffness_ff <= '0;
         damp_in_ff   <= '0;
         damp_out_ff  <= '0;
         thickness_ff <= '0;
         damp_offs_ff <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         if (req_xfer) begin
            mode_ff     <= mode_in;
            stiff_en_ff <= stiff_en_in;
            damp_en_ff  <= damp_en_in;
         end
         if (csr_wr) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_STIFFNESS: stiffness_ff <= csr_pwdata;
               REG_DAMP_IN:   damp_in_ff   <= csr_pwdata;
               REG_DAMP_OUT:  damp_out_ff  <= csr_pwdata;
               REG_THICKNESS: thickness_ff <= csr_pwdata[DATA_W-2:0];
               REG_DAMP_OFFS: damp_offs_ff <= csr_pwdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Operand selection; each product is taken from the multiplier output register by the next step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         STEP_NV0: begin
            mul_a = {nx_ff[DATA_W-1], nx_ff};
            mul_b = {vx_ff[DATA_W-1], vx_ff};
         end
         STEP_NV1: begin
            mul_a = {ny_ff[DATA_W-1], ny_ff};
            mul_b = {vy_ff[DATA_W-1], vy_ff};
         end
         STEP_NV2: begin
            mul_a = {nz_ff[DATA_W-1], nz_ff};
            mul_b = {vz_ff[DATA_W-1], vz_ff};
         end
         STEP_SPRING: begin
            mul_a = {1'b0, stiffness_ff};
            mul_b = -$signed({depth_ff[DATA_W-1], depth_ff});
         end
         STEP_DAMP: begin
            // A zero velocity gives a zero product whichever gain is chosen.
            mul_a = vn_ff[DATA_W-1] ? {1'b0, damp_in_ff} : {1'b0, damp_out_ff};
            mul_b = -$signed({vn_ff[DATA_W-1], vn_ff});
         end
         STEP_FX: begin
            mul_a = {scalar_ff[DATA_W-1], scalar_ff};
            mul_b = {nx_ff[DATA_W-1], nx_ff};
         end
         STEP_FY: begin
            mul_a = {scalar_ff[DATA_W-1], scalar_ff};
            mul_b = {ny_ff[DATA_W-1], ny_ff};
         end
         STEP_FZ: begin
            mul_a = {scalar_ff[DATA_W-1], scalar_ff};
            mul_b = {nz_ff[DATA_W-1], nz_ff};
         end
         default: begin
         end
      endcase
   end

   hwf_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .trunc_q (prod_q)
   );

   assign prod_ext = ACC_W'(prod_q);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         depth_ff <= req_depth;
         nx_ff    <= req_normal_x;
         ny_ff    <= req_normal_y;
         nz_ff    <= req_normal_z;
         vx_ff    <= req_velocity_x;
         vy_ff    <= req_velocity_y;
         vz_ff    <= req_velocity_z;
         fx_in_ff <= req_force_in_x;
         fy_in_ff <= req_force_in_y;
         fz_in_ff <= req_force_in_z;
      end
      if (state_ff == ST_BUSY) begin
         case (step_ff)
            STEP_NV1:    acc_ff <= prod_ext;
            STEP_NV2:    acc_ff <= acc_ff + prod_ext;
            STEP_SPRING: acc_ff <= acc_ff + prod_ext;
            STEP_VSAT: begin
               vn_ff  <= sat_acc(acc_ff);
               acc_ff <= stiff_en_ff ? prod_ext : '0;
            end
            STEP_SUM: begin
               if (damp_en_ff) begin
                  acc_ff <= acc_ff + prod_ext;
               end
            end
            STEP_SCALAR: scalar_ff <= sat_acc(acc_ff);
            STEP_FY:     fx_out_ff <= sat_acc(ACC_W'(fx_in_ff) + prod_ext);
            STEP_FZ:     fy_out_ff <= sat_acc(ACC_W'(fy_in_ff) + prod_ext);
            STEP_LAST:   fz_out_ff <= sat_acc(ACC_W'(fz_in_ff) + prod_ext);
            default: begin
            end
         endcase
      end
      if (out_load) begin
         out_fx_ff   <= fx_out_ff;
         out_fy_ff   <= fy_out_ff;
         out_fz_ff   <= fz_out_ff;
         out_mode_ff <= mode_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_force_out_x = out_fx_ff;
   assign rsp_force_out_y = out_fy_ff;
   assign rsp_force_out_z = out_fz_ff;
   assign rsp_wall_mode   = out_mode_ff;

endmodule

`default_nettype wire
